FILE: rtl/nmea_rmc_time_date_extractor_unit_defines.svh
// Assertion macros used by the port-level checker of the RMC extractor.
`ifndef NMEA_RMC_TIME_DATE_EXTRACTOR_UNIT_DEFINES_SVH
`define NMEA_RMC_TIME_DATE_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define NRMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nmea_rmc: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define NRMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nmea_rmc: next-cycle check failed");

`endif

FILE: rtl/nmea_rmc_pkg.sv
// Package: constants and types of the RMC time and date extractor.
package nmea_rmc_pkg;

  // Character codes
  localparam logic [7:0] CH_STATUS_OK = 8'h41;  // 'A'
  localparam logic [7:0] CH_SPACE     = 8'h20;  // highest terminator code
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] DIGIT_LIMIT  = 8'd10;

  // Capture window
  localparam int unsigned CAP_DEPTH = 6;
  localparam int unsigned CAP_PAIRS = CAP_DEPTH / 2;
  localparam int unsigned OFS_W     = $clog2(CAP_DEPTH + 1);
  localparam logic [OFS_W-1:0] CAP_IDLE = OFS_W'(CAP_DEPTH);

  // Comma counter marks (count before the comma is applied)
  localparam logic [3:0] COMMA_SAT     = 4'd10;
  localparam logic [3:0] COMMA_TIME    = 4'd0;  // first comma opens time window
  localparam logic [3:0] COMMA_STATUS  = 4'd1;  // second comma arms status check
  localparam logic [3:0] COMMA_DATE    = 4'd8;  // ninth comma opens date window
  localparam logic [3:0] COMMA_NEEDED  = 4'd9;

  // Control handed to one capture window
  typedef struct packed {
    logic clear;  // terminator: back to reset value
    logic write;  // sentence byte transferred
    logic start;  // this byte opens the window
  } cap_ctrl_t;

endpackage

FILE: rtl/nmea_rmc_capture.sv
// Six-byte capture window with per-pair BCD conversion.
module nmea_rmc_capture (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nmea_rmc_pkg::cap_ctrl_t ctrl_i,
  input  logic [7:0]            byte_i,
  output logic [7:0]            pair_bcd_o [nmea_rmc_pkg::CAP_PAIRS]
);

  logic [nmea_rmc_pkg::OFS_W-1:0] offset_q, offset_d;
  logic [7:0]                     bytes_q [nmea_rmc_pkg::CAP_DEPTH];
  logic                           active;

  // Two ASCII digits to packed BCD, zero if either is not a digit
  function automatic logic [7:0] to_bcd(input logic [7:0] hi_c, input logic [7:0] lo_c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = hi_c - nmea_rmc_pkg::CH_ZERO;
    lo = lo_c - nmea_rmc_pkg::CH_ZERO;
    if (hi >= nmea_rmc_pkg::DIGIT_LIMIT || lo >= nmea_rmc_pkg::DIGIT_LIMIT) begin
      return 8'h00;
    end
    return {hi[3:0], lo[3:0]};
  endfunction

  assign active = (offset_q < nmea_rmc_pkg::CAP_IDLE);

  // Advance the write offset; a start restarts the window
  always_comb begin
    offset_d = offset_q;
    if (ctrl_i.clear) begin
      offset_d = nmea_rmc_pkg::CAP_IDLE;
    end else if (ctrl_i.write) begin
      if (ctrl_i.start) begin
        offset_d = '0;
      end else if (active) begin
        offset_d = offset_q + nmea_rmc_pkg::OFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= nmea_rmc_pkg::CAP_IDLE;
    end else begin
      offset_q <= offset_d;
    end
  end

  // Capture raw bytes; clear the window at each terminator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < nmea_rmc_pkg::CAP_DEPTH; i++) begin
        bytes_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < nmea_rmc_pkg::CAP_DEPTH; i++) begin
        bytes_q[i] <= '0;
      end
    end else if (ctrl_i.write && active) begin
      for (int i = 0; i < nmea_rmc_pkg::CAP_DEPTH; i++) begin
        if (offset_q == nmea_rmc_pkg::OFS_W'(i)) begin
          bytes_q[i] <= byte_i;
        end
      end
    end
  end

  // Convert each pair
  always_comb begin
    for (int p = 0; p < nmea_rmc_pkg::CAP_PAIRS; p++) begin
      pair_bcd_o[p] = to_bcd(bytes_q[2*p], bytes_q[2*p+1]);
    end
  end

endmodule

FILE: rtl/nmea_rmc_time_date_extractor_unit.sv
// Top level: RMC sentence byte stream in, BCD time and date result out.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   char    | char_valid_i, char_stall_o | char_in_i
//   res     | res_valid_o, res_stall_i   | valid_res_o, hour..year _bcd_o
//
// One byte is taken per clock while char is not stalled; sentence state updates in the same cycle.
// A result appears on res in the cycle after its terminator byte is taken,
// from a single output register fed by the capture windows.
// The char side stalls only while a result waits and res is stalled.
// Reset clears all sentence state and the result valid flag; the payload registers have no reset.
module nmea_rmc_time_date_extractor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_valid_i,
  output logic       char_stall_o,
  input  logic [7:0] char_in_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       valid_res_o,
  output logic [7:0] hour_bcd_o,
  output logic [7:0] minute_bcd_o,
  output logic [7:0] second_bcd_o,
  output logic [7:0] day_bcd_o,
  output logic [7:0] month_bcd_o,
  output logic [7:0] year_bcd_o
);

  logic       accept;
  logic       is_term;
  logic       is_comma;
  logic       comma_hit;
  logic       sentence_valid;
  logic       load_res;

  logic [3:0] comma_count_q, comma_count_d;
  logic       status_ok_q, status_ok_d;
  logic       status_next_q, status_next_d;
  logic       started_q, started_d;
  logic       out_valid_q, out_valid_d;

  logic       valid_res_q;
  logic [7:0] hour_q, minute_q, second_q, day_q, month_q, year_q;

  nmea_rmc_pkg::cap_ctrl_t time_ctrl, date_ctrl;
  logic [7:0] time_bcd [nmea_rmc_pkg::CAP_PAIRS];
  logic [7:0] date_bcd [nmea_rmc_pkg::CAP_PAIRS];

  // Handshake
  assign char_stall_o = out_valid_q && res_stall_i;
  assign accept       = char_valid_i && !char_stall_o;

  // Byte classification
  assign is_term   = (char_in_i <= nmea_rmc_pkg::CH_SPACE);
  assign is_comma  = (char_in_i == nmea_rmc_pkg::CH_COMMA);
  assign comma_hit = is_comma && (comma_count_q < nmea_rmc_pkg::COMMA_SAT);

  // Window control
  always_comb begin
    time_ctrl.clear = accept && is_term;
    time_ctrl.write = accept && !is_term;
    time_ctrl.start = comma_hit && (comma_count_q == nmea_rmc_pkg::COMMA_TIME);
    date_ctrl.clear = accept && is_term;
    date_ctrl.write = accept && !is_term;
    date_ctrl.start = comma_hit && (comma_count_q == nmea_rmc_pkg::COMMA_DATE);
  end

  nmea_rmc_capture u_time (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (time_ctrl),
    .byte_i     (char_in_i),
    .pair_bcd_o (time_bcd)
  );

  nmea_rmc_capture u_date (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (date_ctrl),
    .byte_i     (char_in_i),
    .pair_bcd_o (date_bcd)
  );

  // Sentence state: comma count, status check, started flag
  always_comb begin
    comma_count_d = comma_count_q;
    status_ok_d   = status_ok_q;
    status_next_d = status_next_q;
    started_d     = started_q;
    if (accept) begin
      if (is_term) begin
        comma_count_d = '0;
        status_ok_d   = 1'b0;
        status_next_d = 1'b0;
        started_d     = 1'b0;
      end else begin
        started_d = 1'b1;
        if (status_next_q) begin
          status_ok_d   = (char_in_i == nmea_rmc_pkg::CH_STATUS_OK);
          status_next_d = 1'b0;
        end
        if (comma_hit) begin
          comma_count_d = comma_count_q + 4'd1;
          if (comma_count_q == nmea_rmc_pkg::COMMA_STATUS) begin
            status_next_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comma_count_q <= '0;
      status_ok_q   <= 1'b0;
      status_next_q <= 1'b0;
      started_q     <= 1'b0;
    end else begin
      comma_count_q <= comma_count_d;
      status_ok_q   <= status_ok_d;
      status_next_q <= status_next_d;
      started_q     <= started_d;
    end
  end

  // Result register: load on a terminator that ends a non-empty sentence
  assign sentence_valid = status_ok_q && (comma_count_q >= nmea_rmc_pkg::COMMA_NEEDED);
  assign load_res       = accept && is_term && started_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (!res_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload until the next load; zero every field when invalid
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      valid_res_q <= sentence_valid;
      hour_q      <= sentence_valid ? time_bcd[0] : 8'h00;
      minute_q    <= sentence_valid ? time_bcd[1] : 8'h00;
      second_q    <= sentence_valid ? time_bcd[2] : 8'h00;
      day_q       <= sentence_valid ? date_bcd[0] : 8'h00;
      month_q     <= sentence_valid ? date_bcd[1] : 8'h00;
      year_q      <= sentence_valid ? date_bcd[2] : 8'h00;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign valid_res_o  = valid_res_q;
  assign hour_bcd_o   = hour_q;
  assign minute_bcd_o = minute_q;
  assign second_bcd_o = second_q;
  assign day_bcd_o    = day_q;
  assign month_bcd_o  = month_q;
  assign year_bcd_o   = year_q;

endmodule

FILE: rtl/nmea_rmc_checker.sv
// Port-level checker for the RMC extractor, bound to the top level.
`include "nmea_rmc_time_date_extractor_unit_defines.svh"

module nmea_rmc_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       char_valid_i,
  input logic       char_stall_o,
  input logic [7:0] char_in_i,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic       valid_res_o,
  input logic [7:0] hour_bcd_o,
  input logic [7:0] minute_bcd_o,
  input logic [7:0] second_bcd_o,
  input logic [7:0] day_bcd_o,
  input logic [7:0] month_bcd_o,
  input logic [7:0] year_bcd_o
);

  logic term_xfer;
  logic new_result;
  logic all_zero;

  assign term_xfer  = char_valid_i && !char_stall_o && (char_in_i <= nmea_rmc_pkg::CH_SPACE);
  assign new_result = res_valid_o && !res_stall_i;
  assign all_zero   = (hour_bcd_o == 8'h00) && (minute_bcd_o == 8'h00) &&
                      (second_bcd_o == 8'h00) && (day_bcd_o == 8'h00) &&
                      (month_bcd_o == 8'h00) && (year_bcd_o == 8'h00);

  // An invalid sentence reports all fields as zero
  `NRMC_ASSERT_NOW(a_invalid_zero, res_valid_o && !valid_res_o, all_zero)

  // The hour, day and year BCD digits of a shown result are decimal digits
  `NRMC_ASSERT_NOW(a_bcd_digits, res_valid_o,
    (hour_bcd_o[3:0] <= 4'd9) && (hour_bcd_o[7:4] <= 4'd9) &&
    (day_bcd_o[3:0] <= 4'd9) && (day_bcd_o[7:4] <= 4'd9) &&
    (year_bcd_o[3:0] <= 4'd9) && (year_bcd_o[7:4] <= 4'd9))

  // A result that is taken and not replaced means the next cycle is empty
  `NRMC_ASSERT_NEXT(a_no_extra_result, new_result && !term_xfer, !res_valid_o)

  // A stalled result stays shown and holds its valid flag, hour and year
  `NRMC_ASSERT_NEXT(a_stall_hold, res_valid_o && res_stall_i,
    res_valid_o && $stable(valid_res_o) && $stable(hour_bcd_o) && $stable(year_bcd_o))

endmodule

bind nmea_rmc_time_date_extractor_unit nmea_rmc_port_checker u_checker (.*);

FILE: dv/nmea_rmc_checker.sv
// Checker for the RMC extractor: predicts time and date results and compares them.
`timescale 1ns / 1ps

module nmea_rmc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_valid_i,
  input  logic       char_stall_i,
  input  logic [7:0] char_in_i,
  input  logic       res_valid_i,
  input  logic       res_stall_i,
  input  logic       valid_res_i,
  input  logic [7:0] hour_bcd_i,
  input  logic [7:0] minute_bcd_i,
  input  logic [7:0] second_bcd_i,
  input  logic [7:0] day_bcd_i,
  input  logic [7:0] month_bcd_i,
  input  logic [7:0] year_bcd_i,
  output int         mismatches_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic       valid;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } rmc_fix_t;

  // Sentence state of the predictor
  logic [3:0]                     commas_seen;
  logic [7:0]                     time_raw [nmea_rmc_pkg::CAP_DEPTH];
  logic [7:0]                     date_raw [nmea_rmc_pkg::CAP_DEPTH];
  logic [nmea_rmc_pkg::OFS_W-1:0] time_pos;
  logic [nmea_rmc_pkg::OFS_W-1:0] date_pos;
  logic                           status_good;
  logic                           status_due;
  logic                           in_sentence;

  rmc_fix_t expected_fixes [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // Drop everything gathered for the current sentence
  task automatic restart_sentence();
    commas_seen = '0;
    for (int i = 0; i < nmea_rmc_pkg::CAP_DEPTH; i++) begin
      time_raw[i] = '0;
      date_raw[i] = '0;
    end
    time_pos    = nmea_rmc_pkg::CAP_IDLE;
    date_pos    = nmea_rmc_pkg::CAP_IDLE;
    status_good = 1'b0;
    status_due  = 1'b0;
    in_sentence = 1'b0;
  endtask

  // Two ASCII characters to one BCD byte; anything but two digits gives zero
  function automatic logic [7:0] pair_to_bcd(input logic [7:0] tens,
                                             input logic [7:0] units);
    logic [7:0] t;
    logic [7:0] u;
    t = tens - nmea_rmc_pkg::CH_ZERO;
    u = units - nmea_rmc_pkg::CH_ZERO;
    if (t >= nmea_rmc_pkg::DIGIT_LIMIT || u >= nmea_rmc_pkg::DIGIT_LIMIT) return '0;
    return {t[3:0], u[3:0]};
  endfunction

  // Advance the sentence state by one transferred character
  task automatic take_char(input logic [7:0] ch);
    rmc_fix_t fix;
    if (ch <= nmea_rmc_pkg::CH_SPACE) begin
      if (in_sentence) begin
        fix = '0;
        if (status_good && commas_seen >= nmea_rmc_pkg::COMMA_NEEDED) begin
          fix.valid  = 1'b1;
          fix.hour   = pair_to_bcd(time_raw[0], time_raw[1]);
          fix.minute = pair_to_bcd(time_raw[2], time_raw[3]);
          fix.second = pair_to_bcd(time_raw[4], time_raw[5]);
          fix.day    = pair_to_bcd(date_raw[0], date_raw[1]);
          fix.month  = pair_to_bcd(date_raw[2], date_raw[3]);
          fix.year   = pair_to_bcd(date_raw[4], date_raw[5]);
        end
        expected_fixes.push_back(fix);
      end
      restart_sentence();
    end else begin
      in_sentence = 1'b1;
      if (status_due) begin
        status_good = (ch == nmea_rmc_pkg::CH_STATUS_OK);
        status_due  = 1'b0;
      end
      // Capture raw, commas included
      if (time_pos < nmea_rmc_pkg::CAP_IDLE) begin
        time_raw[time_pos] = ch;
        time_pos++;
      end
      if (date_pos < nmea_rmc_pkg::CAP_IDLE) begin
        date_raw[date_pos] = ch;
        date_pos++;
      end
      if (ch == nmea_rmc_pkg::CH_COMMA && commas_seen < nmea_rmc_pkg::COMMA_SAT) begin
        if (commas_seen == nmea_rmc_pkg::COMMA_TIME) time_pos = '0;
        else if (commas_seen == nmea_rmc_pkg::COMMA_STATUS) status_due = 1'b1;
        else if (commas_seen == nmea_rmc_pkg::COMMA_DATE) date_pos = '0;
        commas_seen++;
      end
    end
  endtask

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: expected %02h, got %02h",
                              checked_o, name, want, got));
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic compare_fix();
    rmc_fix_t want;
    if (expected_fixes.size() == 0) begin
      flag_mismatch("result transfer with no result outstanding");
    end else begin
      want = expected_fixes.pop_front();
      check_field("valid", {7'd0, want.valid}, {7'd0, valid_res_i});
      check_field("hour", want.hour, hour_bcd_i);
      check_field("minute", want.minute, minute_bcd_i);
      check_field("second", want.second, second_bcd_i);
      check_field("day", want.day, day_bcd_i);
      check_field("month", want.month, month_bcd_i);
      check_field("year", want.year, year_bcd_i);
    end
    checked_o++;
  endtask

  // Watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_sentence();
      expected_fixes.delete();
    end else begin
      if (res_valid_i && !res_stall_i) compare_fix();
      if (char_valid_i && !char_stall_i) take_char(char_in_i);
    end
    pending_o = expected_fixes.size();
  end

endmodule

FILE: dv/testbench.sv
// Testbench top: drives RMC sentences into the extractor and reports the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int CHAR_TARGET = 1600;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       char_valid_i = 1'b0;
  logic       char_stall_o;
  logic [7:0] char_in_i    = '0;
  logic       res_valid_o;
  logic       res_stall_i  = 1'b0;
  logic       valid_res_o;
  logic [7:0] hour_bcd_o;
  logic [7:0] minute_bcd_o;
  logic [7:0] second_bcd_o;
  logic [7:0] day_bcd_o;
  logic [7:0] month_bcd_o;
  logic [7:0] year_bcd_o;

  int mismatches;
  int pending;
  int checked;
  int cycle_count = 0;
  int chars_sent  = 0;
  int burst_left  = 0;
  bit calm        = 1'b0;

  nmea_rmc_time_date_extractor_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid_i),
    .char_stall_o (char_stall_o),
    .char_in_i    (char_in_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .valid_res_o  (valid_res_o),
    .hour_bcd_o   (hour_bcd_o),
    .minute_bcd_o (minute_bcd_o),
    .second_bcd_o (second_bcd_o),
    .day_bcd_o    (day_bcd_o),
    .month_bcd_o  (month_bcd_o),
    .year_bcd_o   (year_bcd_o)
  );

  nmea_rmc_checker fix_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid_i),
    .char_stall_i (char_stall_o),
    .char_in_i    (char_in_i),
    .res_valid_i  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .valid_res_i  (valid_res_o),
    .hour_bcd_i   (hour_bcd_o),
    .minute_bcd_i (minute_bcd_o),
    .second_bcd_i (second_bcd_o),
    .day_bcd_i    (day_bcd_o),
    .month_bcd_i  (month_bcd_o),
    .year_bcd_i   (year_bcd_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the result side: free, random, or a periodic hold, switching now and then
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: res_stall_i <= 1'b0;
      1: res_stall_i <= 1'($urandom_range(0, 1));
      default: res_stall_i <= ((cycle_count % 16) < 11);
    endcase
  end

  // Transfer one character; open a new burst after a random gap when needed
  task automatic send_char(input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      burst_left = $urandom_range(1, 24);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        char_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    char_valid_i <= 1'b1;
    char_in_i    <= ch;
    @(posedge clk_i);
    while (char_stall_o) @(posedge clk_i);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Any non-terminator, non-comma character
  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(nmea_rmc_pkg::CH_SPACE + 1, 255));
    while (ch == nmea_rmc_pkg::CH_COMMA);
    return ch;
  endfunction

  // Mostly a decimal digit, sometimes junk
  function automatic logic [7:0] digit_char();
    if ($urandom_range(0, 9) == 0) return text_char();
    return nmea_rmc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_terminator();
    send_char(8'($urandom_range(0, nmea_rmc_pkg::CH_SPACE)));
  endtask

  // Time or date block: usually six digits, sometimes short or with a tail
  task automatic send_stamp();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 6;
    repeat (n) send_char(digit_char());
    if (n == 6 && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_char(text_char());
  endtask

  task automatic send_filler();
    repeat ($urandom_range(0, 4)) send_char(text_char());
  endtask

  // One random sentence: mostly well formed, the rest broken or pure noise
  task automatic send_random_sentence();
    int pick;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 30)) send_char(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) != 0) send_text("$GPRMC");
    else send_filler();
    send_char(nmea_rmc_pkg::CH_COMMA);
    send_stamp();
    if ($urandom_range(0, 15) == 0) begin
      send_terminator();
      return;
    end
    send_char(nmea_rmc_pkg::CH_COMMA);
    // Status byte: 'A', something else, an empty field, or the sentence end
    pick = $urandom_range(0, 9);
    if (pick < 7) send_char(nmea_rmc_pkg::CH_STATUS_OK);
    else if (pick == 7) send_char(text_char());
    else if (pick == 8) send_char(nmea_rmc_pkg::CH_COMMA);
    else begin
      send_terminator();
      return;
    end
    // Fields between status and date, now and then one dropped
    for (int f = 0; f < 6; f++) begin
      if ($urandom_range(0, 24) != 0) begin
        send_char(nmea_rmc_pkg::CH_COMMA);
        send_filler();
      end
    end
    send_char(nmea_rmc_pkg::CH_COMMA);
    send_stamp();
    // Extra fields can push the comma count to saturation
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_char(nmea_rmc_pkg::CH_COMMA);
        send_filler();
      end
    end
    send_terminator();
    if ($urandom_range(0, 7) == 0) send_terminator();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty sentence, then a clean fix with the largest digits, then a bare 0xFF
    send_char(nmea_rmc_pkg::CH_SPACE);
    send_text(",235959,A");
    repeat (7) send_char(nmea_rmc_pkg::CH_COMMA);
    send_text("311299");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(nmea_rmc_pkg::CH_SPACE);

    while (chars_sent < CHAR_TARGET) send_random_sentence();
    char_valid_i <= 1'b0;

    // Let the last transfer reach the predictor, drain, then allow for the output register
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d transferred characters and %0d checked time/date results",
             chars_sent, checked);
    $display("(%0d field mismatches, %0d results outstanding)", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/nmea_rmc_pkg.sv
rtl/nmea_rmc_capture.sv
rtl/nmea_rmc_time_date_extractor_unit.sv
rtl/nmea_rmc_checker.sv
dv/nmea_rmc_checker.sv
dv/testbench.sv
